// ===== sv/tmcw_pkg.sv =====
// shared types, constants and codes for the text console writer
`timescale 1ns / 1ps

package tmcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int ACT_W   = 2;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int IDX_W   = 11;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CELL_W  = COLOR_W + CHAR_W;

   typedef logic [ACT_W-1:0]   action_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [IDX_W-1:0]   index_type;
   typedef logic [ROW_W-1:0]   cur_row_type;
   typedef logic [COL_W-1:0]   cur_col_type;
   typedef logic [CELL_W-1:0]  cell_type;

   localparam action_type ACT_PUT   = 2'd0;
   localparam action_type ACT_CLEAR = 2'd1;
   localparam action_type ACT_READ  = 2'd2;

   localparam char_type CH_NEWLINE   = 8'h0A;
   localparam char_type CH_RETURN    = 8'h0D;
   localparam char_type CH_BACKSPACE = 8'h08;
   localparam char_type BLANK_CHAR   = 8'h20;

   localparam color_type RESET_COLOR = 8'h0F;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

endpackage

// ===== sv/tmcw_if.sv =====
// request and response channel interfaces of the text console writer
`timescale 1ns / 1ps

interface tmcw_req_if import tmcw_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;
   char_type   char_code;
   index_type  cell_index;

   modport source (output valid, output action, output char_code, output cell_index,
                   input ready);
   modport sink (input valid, input action, input char_code, input cell_index,
                 output ready);
endinterface

interface tmcw_rsp_if import tmcw_pkg::*; ();
   logic        valid;
   logic        ready;
   cur_row_type cursor_row;
   cur_col_type cursor_col;
   cell_type    cell_value;
   logic        scrolled;

   modport source (output valid, output cursor_row, output cursor_col, output cell_value,
                   output scrolled, input ready);
   modport sink (input valid, input cursor_row, input cursor_col, input cell_value,
                 input scrolled, output ready);
endinterface

// ===== sv/tmcw_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tmcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/text_mode_console_writer.sv =====
// text console writer: screen store, cursor, scroll and clear sequencer
// path: idle, execute, registered result beat for a plain put; a read adds the read state
// scroll and clear walk the store one cell a cycle in the sweep state
// a new item is taken only in the idle state, after the last one has finished
// reset: cursor homes, text_color = 0x0F, then a clearing pass in the sweep and drain
// states fills the store with 0x0F20 while req_chan.ready stays low
`timescale 1ns / 1ps

module text_mode_console_writer import tmcw_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   tmcw_req_if.sink              req_chan,
   tmcw_rsp_if.source            rsp_chan
);

   localparam int CELLS      = COLUMNS * ROWS;
   localparam int AW         = $clog2(CELLS);
   localparam int CW         = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);
   localparam int COPY_CELLS = CELLS - COLUMNS;
   localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXEC  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_SWEEP = 7'b0001000,
      S_DRAIN = 7'b0010000,
      S_RESP  = 7'b0100000,
      S_HOLD  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      init_ff, init_in;
   color_type color_ff, color_in;
   action_type act_ff, act_in;
   char_type  char_ff, char_in;
   index_type idx_ff, idx_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          copy_ff, copy_in;
   logic          wpend_ff, wpend_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic          wblank_ff, wblank_in;
   logic          scr_ff, scr_in;
   cell_type      val_ff, val_in;
   logic          rsp_valid_ff, rsp_valid_in;
   cur_row_type   rsp_row_ff, rsp_row_in;
   cur_col_type   rsp_col_ff, rsp_col_in;
   cell_type      rsp_val_ff, rsp_val_in;
   logic          rsp_scr_ff, rsp_scr_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   cell_type      ram_wdata;
   logic [AW-1:0] ram_raddr;
   cell_type      ram_rdata;

   logic csr_wr;
   color_type blank_color;

   tmcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign csr_wr      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = csr_paddr[2] ? '0 : CSR_DATA_W'(color_ff);
   assign blank_color = init_ff ? RESET_COLOR : color_ff;

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cursor_row = rsp_row_ff;
   assign rsp_chan.cursor_col = rsp_col_ff;
   assign rsp_chan.cell_value = rsp_val_ff;
   assign rsp_chan.scrolled   = rsp_scr_ff;

   always_comb begin
      logic [CW:0]   col_inc;
      logic [RW:0]   row_n;
      logic [AW:0]   pos_n;
      logic          done;
      logic          out_free;
      state_type     nxt;

      state_in     = state_ff;
      init_in      = init_ff;
      color_in     = color_ff;
      act_in       = act_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      copy_in      = copy_ff;
      wpend_in     = 1'b0;
      waddr_in     = waddr_ff;
      wblank_in    = wblank_ff;
      scr_in       = scr_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_scr_in   = rsp_scr_ff;
      done         = 1'b0;
      nxt          = state_ff;
      out_free     = !rsp_valid_ff || rsp_chan.ready;

      ram_we    = wpend_ff;
      ram_waddr = waddr_ff;
      ram_wdata = wblank_ff ? {blank_color, BLANK_CHAR} : ram_rdata;
      ram_raddr = AW'(32'(cnt_ff) + COLUMNS);

      col_inc = {1'b0, col_ff} + 1'b1;
      row_n   = {1'b0, row_ff};
      pos_n   = {1'b0, pos_ff};

      if (csr_wr && !csr_paddr[2]) begin
         color_in = csr_pwdata[COLOR_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in  = req_chan.action;
               char_in = req_chan.char_code;
               idx_in  = req_chan.cell_index;
               nxt     = S_EXEC;
            end
         end
         S_EXEC: begin
            scr_in = 1'b0;
            val_in = '0;
            case (act_ff)
               ACT_PUT: begin
                  case (char_ff)
                     CH_NEWLINE: begin
                        col_in = '0;
                        row_n  = {1'b0, row_ff} + 1'b1;
                        pos_n  = {1'b0, pos_ff} - (AW+1)'(col_ff) + (AW+1)'(COLUMNS);
                     end
                     CH_RETURN: begin
                        col_in = '0;
                        pos_n  = {1'b0, pos_ff} - (AW+1)'(col_ff);
                     end
                     CH_BACKSPACE: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                           pos_n  = {1'b0, pos_ff} - 1'b1;
                        end else if (row_ff != '0) begin
                           row_n  = {1'b0, row_ff} - 1'b1;
                           col_in = CW'(COLUMNS - 1);
                           pos_n  = {1'b0, pos_ff} - 1'b1;
                        end
                        ram_we    = 1'b1;
                        ram_waddr = pos_n[AW-1:0];
                        ram_wdata = {color_ff, BLANK_CHAR};
                     end
                     default: begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_ff;
                        ram_wdata = {color_ff, char_ff};
                        pos_n     = {1'b0, pos_ff} + 1'b1;
                        if (32'(col_inc) == COLUMNS) begin
                           col_in = '0;
                           row_n  = {1'b0, row_ff} + 1'b1;
                        end else begin
                           col_in = col_inc[CW-1:0];
                        end
                     end
                  endcase
                  if (32'(row_n) == ROWS) begin
                     row_in  = RW'(ROWS - 1);
                     pos_in  = AW'(LAST_BASE);
                     scr_in  = 1'b1;
                     copy_in = 1'b1;
                     cnt_in  = '0;
                     nxt     = S_SWEEP;
                  end else begin
                     row_in = row_n[RW-1:0];
                     pos_in = pos_n[AW-1:0];
                     done   = 1'b1;
                  end
               end
               ACT_CLEAR: begin
                  row_in  = '0;
                  col_in  = '0;
                  pos_in  = '0;
                  copy_in = 1'b0;
                  cnt_in  = '0;
                  nxt     = S_SWEEP;
               end
               ACT_READ: begin
                  ram_raddr = AW'(idx_ff);
                  nxt       = S_READ;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         S_READ: begin
            val_in = (32'(idx_ff) < CELLS) ? ram_rdata : '0;
            done   = 1'b1;
         end
         S_SWEEP: begin
            wpend_in  = 1'b1;
            waddr_in  = cnt_ff;
            wblank_in = !(copy_ff && (32'(cnt_ff) < COPY_CELLS));
            if (32'(cnt_ff) == CELLS - 1) begin
               nxt = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (init_ff) begin
               init_in = 1'b0;
               nxt     = S_IDLE;
            end else begin
               done = 1'b1;
            end
         end
         S_RESP: begin
            done = 1'b1;
         end
         S_HOLD: begin
            nxt = S_IDLE;
         end
         default: begin
            nxt = S_IDLE;
         end
      endcase

      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = cur_row_type'(row_in);
            rsp_col_in   = cur_col_type'(col_in);
            rsp_val_in   = val_in;
            rsp_scr_in   = scr_in;
            nxt          = S_IDLE;
         end else begin
            nxt = S_RESP;
         end
      end
      state_in = nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         init_ff      <= 1'b1;
         color_ff     <= RESET_COLOR;
         row_ff       <= '0;
         col_ff       <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         copy_ff      <= 1'b0;
         wpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         color_ff     <= color_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         copy_ff      <= copy_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff     <= act_in;
      char_ff    <= char_in;
      idx_ff     <= idx_in;
      waddr_ff   <= waddr_in;
      wblank_ff  <= wblank_in;
      scr_ff     <= scr_in;
      val_ff     <= val_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_val_ff <= rsp_val_in;
      rsp_scr_ff <= rsp_scr_in;
   end

   a_cursor_linear: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff))
      else $error("linear cursor out of step with row and column");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS))
      else $error("cursor outside the screen");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wpend_ff |-> 32'(waddr_ff) < CELLS)
      else $error("sweep write beyond the store");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_EXEC))
      else $error("accepted beat not executed");

   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP || state_ff == S_DRAIN) |-> !req_chan.ready)
      else $error("input taken during store sweep");

endmodule
